[hdl/hpf_pkg.sv]
// ----------------------------------------------------------------------------
// hpf_pkg
// Types and constants shared by the first-order high-pass filter modules.
// ----------------------------------------------------------------------------
package hpf_pkg;

	localparam int SAMPLE_W = 8;
	localparam int COEF_W   = 16;
	localparam int OUT_W    = 16;
	localparam int SUM_W    = 18;
	localparam int PROD_W   = OUT_W + COEF_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_COEFFICIENT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIGNED = 1'd1;

	localparam logic signed [PROD_W:0] ROUND_POS = 34'sh0_0000_8000;
	localparam logic signed [PROD_W:0] ROUND_NEG = 34'sh0_0000_7FFF;
	localparam logic signed [SUM_W-1:0] SUM_MAX  = 18'sh0_7FFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN  = -18'sh0_8000;
	localparam logic signed [OUT_W-1:0] OUT_MAX  = 16'sh7FFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN  = 16'sh8000;

	typedef struct packed {
		logic [COEF_W-1:0] coefficient;
		logic              input_signed;
	} cfg_t;

endpackage

[hdl/highpass_first_order_q16.sv]
// ----------------------------------------------------------------------------
// highpass_first_order_q16
// First-order high-pass filter, 8-bit samples in, 16-bit output.
// An accepted sample passes the sample register, then the output register.
// Throughput: one word per cycle unless the receiver stalls; the filter state
// updates in the single compute stage between the sample and output registers.
// Reset: state, valids and coefficient clear; signed mode is selected.
// ----------------------------------------------------------------------------
module highpass_first_order_q16 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hpf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [hpf_pkg::SAMPLE_W-1:0]   sample,
	output logic                           filtered_valid,
	input  logic                           filtered_stall,
	output logic signed [hpf_pkg::OUT_W-1:0] filtered
);
	import hpf_pkg::*;

	cfg_t                     cfg;
	logic                     valid_s1;
	logic [SAMPLE_W-1:0]      sample_s1;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  filtered_q;
	logic signed [OUT_W-1:0]  prev_output_q;
	logic [SAMPLE_W-1:0]      prev_sample_q;
	logic signed [OUT_W-1:0]  result;
	logic                     out_open;
	logic                     advance;

	hpf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hpf_step u_step (
		.cfg         (cfg),
		.sample      (sample_s1),
		.prev_sample (prev_sample_q),
		.prev_output (prev_output_q),
		.result      (result)
	);

	assign out_open     = !out_valid_q || !filtered_stall;
	assign advance      = valid_s1 && out_open;
	assign sample_stall = valid_s1 && !out_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			prev_output_q <= '0;
			prev_sample_q <= '0;
		end else begin
			if (out_open) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				prev_output_q <= result;
				prev_sample_q <= sample_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filtered_q <= result;
		end
	end

	assign filtered_valid = out_valid_q;
	assign filtered       = filtered_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with no word held");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && filtered_q == prev_output_q)
		else $error("output word differs from filter state");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(prev_output_q) && $stable(prev_sample_q))
		else $error("filter state changed without a word advancing");

endmodule

[hdl/hpf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// hpf_cfg_regs
// Configuration registers: decay coefficient and sample signedness.
// ----------------------------------------------------------------------------
module hpf_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hpf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hpf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output hpf_pkg::cfg_t                    cfg
);
	import hpf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coefficient  <= '0;
			cfg_q.input_signed <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COEFFICIENT:  cfg_q.coefficient  <= cfg_data[COEF_W-1:0];
				CFG_INPUT_SIGNED: cfg_q.input_signed <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/hpf_step.sv]
// ----------------------------------------------------------------------------
// hpf_step
// One filter update: decay, rounding, sample difference, saturate or wrap,
// and the unchanged-output nudge toward zero.
// ----------------------------------------------------------------------------
module hpf_step (
	input  hpf_pkg::cfg_t                     cfg,
	input  logic        [hpf_pkg::SAMPLE_W-1:0] sample,
	input  logic        [hpf_pkg::SAMPLE_W-1:0] prev_sample,
	input  logic signed [hpf_pkg::OUT_W-1:0]    prev_output,
	output logic signed [hpf_pkg::OUT_W-1:0]    result
);
	import hpf_pkg::*;

	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W:0]     rnd;
	logic signed [SUM_W-1:0]    decay;
	logic signed [SUM_W-1:0]    yold;
	logic signed [SUM_W-1:0]    base;
	logic signed [SAMPLE_W:0]   cur_ext;
	logic signed [SAMPLE_W:0]   prv_ext;
	logic signed [SAMPLE_W+1:0] diff;
	logic signed [SUM_W-1:0]    step;
	logic signed [SUM_W-1:0]    sum;
	logic signed [OUT_W-1:0]    nudge;

	assign prod  = prev_output * $signed({1'b0, cfg.coefficient});
	assign rnd   = {prod[PROD_W-1], prod} + (prod[PROD_W-1] ? ROUND_NEG : ROUND_POS);
	assign decay = rnd[PROD_W:COEF_W];
	assign yold  = {{(SUM_W-OUT_W){prev_output[OUT_W-1]}}, prev_output};
	assign base  = yold - decay;

	assign cur_ext = {cfg.input_signed & sample[SAMPLE_W-1], sample};
	assign prv_ext = {cfg.input_signed & prev_sample[SAMPLE_W-1], prev_sample};
	assign diff    = {cur_ext[SAMPLE_W], cur_ext} - {prv_ext[SAMPLE_W], prv_ext};
	assign step    = {diff[SAMPLE_W+1], diff, 7'b0};
	assign sum     = base + step;

	always_comb begin
		if (prev_output[OUT_W-1]) begin
			nudge = prev_output + 16'sd1;
		end else if (prev_output != '0) begin
			nudge = prev_output - 16'sd1;
		end else begin
			nudge = '0;
		end
	end

	always_comb begin
		if (cfg.input_signed) begin
			if (sum == yold) begin
				result = nudge;
			end else if (sum > SUM_MAX) begin
				result = OUT_MAX;
			end else if (sum < SUM_MIN) begin
				result = OUT_MIN;
			end else begin
				result = sum[OUT_W-1:0];
			end
		end else begin
			if (sum[OUT_W-1:0] == prev_output) begin
				result = nudge;
			end else begin
				result = sum[OUT_W-1:0];
			end
		end
	end

endmodule

[tb/sv/tb_highpass_first_order_q16.sv]
// ----------------------------------------------------------------------------
// tb_highpass_first_order_q16
// Self-checking bench for the first-order high-pass filter. A directed table
// covers reset state, held samples, saturation, wrap and mode switches, then
// random words run under three sender/receiver stall mixes with reconfiguration
// between blocks; words are checked against table values or an in-bench model.
// ----------------------------------------------------------------------------
module tb_highpass_first_order_q16;
	timeunit 1ns;
	timeprecision 1ps;

	import hpf_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int BLOCK_WORDS  = 50;
	localparam int BLOCKS       = 7;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;

	typedef enum logic [1:0] {ROW_SAMPLE, ROW_COEF, ROW_MODE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [15:0]        value;
		bit                 typed;
		logic signed [15:0] want;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     sample_valid = 1'b0;
	logic                     sample_stall;
	logic [SAMPLE_W-1:0]      sample = '0;
	logic                     filtered_valid;
	logic                     filtered_stall = 1'b0;
	logic signed [OUT_W-1:0]  filtered;

	logic [COEF_W-1:0]        coef_q;
	bit                       signed_mode;
	logic signed [OUT_W-1:0]  y_prev;
	logic [SAMPLE_W-1:0]      x_prev;

	logic signed [OUT_W-1:0]  filtered_q[$];
	dir_row_t                 dir_rows[$];
	int                       err_cnt = 0;
	int                       cycle_cnt = 0;
	int                       tx_idle_pct = 0;
	int                       rx_idle_pct = 0;
	int                       results_seen = 0;
	int                       hold_left = 0;
	bit                       hold_done = 1'b0;
	logic [SAMPLE_W-1:0]      last_sent = '0;

	highpass_first_order_q16 u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.filtered_valid (filtered_valid),
		.filtered_stall (filtered_stall),
		.filtered       (filtered)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic signed [OUT_W-1:0] filter_next(input logic [SAMPLE_W-1:0] raw);
		longint prod;
		longint mag;
		longint q;
		int yold;
		int base;
		int diff;
		int sum;
		logic signed [OUT_W-1:0] res;
		yold = y_prev;
		prod = longint'(yold) * longint'({16'd0, coef_q});
		mag = (prod < 0) ? -prod : prod;
		q = (mag + 64'sd32768) >>> 16;
		base = yold - int'((prod < 0) ? -q : q);
		if (signed_mode) begin
			diff = int'($signed(raw)) - int'($signed(x_prev));
			sum = base + diff * 128;
		end else begin
			diff = int'({24'd0, raw}) - int'({24'd0, x_prev});
			sum = base + diff * 128;
			sum = int'($signed(sum[15:0]));
		end
		if (sum == yold)
			res = (yold > 0) ? OUT_W'(yold - 1) : (yold < 0) ? OUT_W'(yold + 1) : '0;
		else if (signed_mode && sum > 32767)
			res = OUT_MAX;
		else if (signed_mode && sum < -32768)
			res = OUT_MIN;
		else
			res = sum[15:0];
		y_prev = res;
		x_prev = raw;
		return res;
	endfunction

	task automatic send_word(input logic [SAMPLE_W-1:0] s, input bit typed,
			input logic signed [OUT_W-1:0] want);
		logic signed [OUT_W-1:0] pred;
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		pred = filter_next(s);
		filtered_q.push_back(typed ? want : pred);
		last_sent = s;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		sample_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_COEFFICIENT)
			coef_q = data;
		else if (idx == CFG_INPUT_SIGNED)
			signed_mode = data[0];
	endtask

	// receiver: check each accepted word, then choose next stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && filtered_valid && !filtered_stall) begin
				results_seen++;
				if (filtered_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected filtered word %0d", filtered);
				end else begin
					if (filtered !== filtered_q[0]) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("filtered mismatch: expected %0d actual %0d",
								filtered_q[0], filtered);
					end
					void'(filtered_q.pop_front());
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				filtered_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				filtered_stall <= 1'b1;
			end else begin
				filtered_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] s;
		coef_q = '0;
		signed_mode = 1'b1;
		y_prev = '0;
		x_prev = '0;

		// reset state, held samples, saturation, wrap, mode switches
		dir_rows.push_back('{ROW_SAMPLE, 16'h0000, 1'b1, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h007F, 1'b1, 16'sd16256});
		dir_rows.push_back('{ROW_SAMPLE, 16'h007F, 1'b1, 16'sd16255});
		dir_rows.push_back('{ROW_SAMPLE, 16'h0080, 1'b1, -16'sd16385});
		dir_rows.push_back('{ROW_SAMPLE, 16'h0080, 1'b1, -16'sd16384});
		dir_rows.push_back('{ROW_SAMPLE, 16'h007F, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_MODE,   16'hFFFE, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h00FF, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_MODE,   16'h0001, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h007F, 1'b1, 16'sd32767});
		dir_rows.push_back('{ROW_MODE,   16'h0000, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h00FF, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h00FF, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h007F, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_MODE,   16'hFFFF, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h0080, 1'b1, -16'sd32768});
		dir_rows.push_back('{ROW_COEF,   16'hFFFF, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h0080, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h007F, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h007F, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_COEF,   16'h8000, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h0080, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h0080, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_COEF,   16'h0001, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h0055, 1'b0, 16'sd0});
		dir_rows.push_back('{ROW_SAMPLE, 16'h00AA, 1'b0, 16'sd0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_SAMPLE: begin
					send_word(dir_rows[i].value[7:0], dir_rows[i].typed, dir_rows[i].want);
				end
				ROW_COEF: begin
					write_reg(CFG_COEFFICIENT, dir_rows[i].value);
				end
				default: begin
					write_reg(CFG_INPUT_SIGNED, dir_rows[i].value);
				end
			endcase
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 24;
					rx_idle_pct = 60;
				end
				1: begin
					tx_idle_pct = 60;
					rx_idle_pct = 24;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < BLOCKS; blk++) begin
				case ($urandom_range(4))
					0: write_reg(CFG_COEFFICIENT, 16'h0000);
					1: write_reg(CFG_COEFFICIENT, 16'hFFFF);
					2: write_reg(CFG_COEFFICIENT, 16'($urandom));
					3: write_reg(CFG_COEFFICIENT, 16'($urandom_range(255)));
					default: write_reg(CFG_COEFFICIENT, 16'h8000);
				endcase
				write_reg(CFG_INPUT_SIGNED, 16'($urandom));
				for (int n = 0; n < BLOCK_WORDS; n++) begin
					case ($urandom_range(9))
						5: s = last_sent;
						6: s = 8'h7F;
						7: s = 8'h80;
						8: s = 8'h00;
						9: s = 8'hFF;
						default: s = 8'($urandom);
					endcase
					send_word(s, 1'b0, '0);
				end
			end
		end

		sample_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0 && filtered_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
